[rtl/rcp_pkg.sv]
package rcp_pkg;

	localparam int IDX_W  = 6;
	localparam int MD_W   = 21;
	localparam int DT_W   = 16;
	localparam int DIVN_W = 54;
	localparam int DIVD_W = 33;

	typedef logic signed [31:0] fix_t;

	localparam logic [11:0] RESET_SPACING = 12'd3277;
	localparam logic [19:0] GRAV_MAG      = 20'd642253;
	localparam logic [15:0] DAMP_Q16      = 16'd65208;
	localparam logic [19:0] DRAG_DIV      = 20'd10;

	// datapath operation codes
	localparam logic [4:0] OP_NOP   = 5'd0;
	localparam logic [4:0] OP_CLEAR = 5'd1;
	localparam logic [4:0] OP_TAKE  = 5'd2;
	localparam logic [4:0] OP_GMUL  = 5'd3;
	localparam logic [4:0] OP_GSET  = 5'd4;
	localparam logic [4:0] OP_EMIT0 = 5'd5;
	localparam logic [4:0] OP_LOAD  = 5'd6;
	localparam logic [4:0] OP_GRAV  = 5'd7;
	localparam logic [4:0] OP_MMUL  = 5'd8;
	localparam logic [4:0] OP_MADD  = 5'd9;
	localparam logic [4:0] OP_DIFF  = 5'd10;
	localparam logic [4:0] OP_SMUL  = 5'd11;
	localparam logic [4:0] OP_SACC  = 5'd12;
	localparam logic [4:0] OP_CMP   = 5'd13;
	localparam logic [4:0] OP_SQRT  = 5'd14;
	localparam logic [4:0] OP_PMUL  = 5'd15;
	localparam logic [4:0] OP_PDIV  = 5'd16;
	localparam logic [4:0] OP_PADD  = 5'd17;
	localparam logic [4:0] OP_VDIV  = 5'd18;
	localparam logic [4:0] OP_VSET  = 5'd19;
	localparam logic [4:0] OP_DMUL  = 5'd20;
	localparam logic [4:0] OP_DSET  = 5'd21;
	localparam logic [4:0] OP_WRITE = 5'd22;
	localparam logic [4:0] OP_EMIT  = 5'd23;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic far;
		logic div_busy;
		logic out_free;
	} sts_t;

	function automatic fix_t sat32(input logic signed [63:0] v);
		fix_t r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input fix_t f);
		logic [31:0] u;
		u = f[31] ? (~f + 32'd1) : f;
		return u;
	endfunction

	function automatic logic signed [63:0] sgn_apply(input logic neg, input logic [53:0] m);
		logic signed [63:0] s;
		s = $signed({10'b0, m});
		return neg ? -s : s;
	endfunction

endpackage

[rtl/rcp_div.sv]
module rcp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rcp_pkg::DIVN_W-1:0]  num,
	input  logic [rcp_pkg::DIVD_W-1:0]  den,
	output logic                        busy,
	output logic [rcp_pkg::DIVN_W-1:0]  quo
);
	import rcp_pkg::*;

	// rounded quotient (num + den/2) / den, one bit a cycle
	logic                busy_q;
	logic [5:0]          cnt_q;
	logic [DIVN_W-1:0]   dvd_q;
	logic [DIVD_W-1:0]   rem_q;
	logic [DIVD_W-1:0]   den_q;
	logic [DIVD_W:0]     rem_sh;
	logic                fits;

	assign rem_sh = {rem_q, dvd_q[DIVN_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(DIVN_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= num + DIVN_W'(den >> 1);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DIVD_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIVD_W-1:0];
			dvd_q <= {dvd_q[DIVN_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = dvd_q;

endmodule

[rtl/rcp_dp.sv]
module rcp_dp #(
	parameter int NUM_POINTS = 32,
	parameter int IW = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rcp_pkg::cmd_t           cmd,
	input  logic [IW-1:0]           idx,
	output rcp_pkg::sts_t           sts,
	input  logic                    cfg_we,
	input  logic [rcp_pkg::MD_W-1:0] cfg_wdata,
	input  logic [31:0]             anchor_x,
	input  logic [31:0]             anchor_y,
	input  logic [31:0]             anchor_z,
	input  logic [rcp_pkg::DT_W-1:0] step_time,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [rcp_pkg::IDX_W-1:0] point_index,
	output logic [31:0]             pos_x,
	output logic [31:0]             pos_y,
	output logic [31:0]             pos_z,
	output logic                    last_point
);
	import rcp_pkg::*;

	logic [95:0] mem_pos [NUM_POINTS];
	logic [95:0] mem_vel [NUM_POINTS];
	logic [95:0] rd_pos_q, rd_vel_q;

	logic [MD_W-1:0] md_q;
	logic [DT_W-1:0] dt_q;
	fix_t            gain_q;
	fix_t            prev_q [3];
	fix_t            p_q [3];
	fix_t            v_q [3];
	fix_t            d_q [3];
	logic [63:0]     sum_q, mul_q;
	logic            neg_q;
	logic [63:0]     sq_n_q, sq_r_q, sq_bit_q;
	logic signed [32:0] drag_q;
	logic            out_valid_q;

	fix_t        p_a, v_a, d_a, prev_a, np;
	logic [31:0] mul_a, mul_b;
	logic [47:0] rnd16;
	logic [63:0] rnd_sum, sq_t;
	logic [41:0] md_sq;
	logic [15:0] dt_div;
	logic [19:0] den_v;
	logic [32:0] drag_mag;
	logic signed [63:0] drag_w;
	logic        div_start, div_busy;
	logic [DIVN_W-1:0] div_num, div_q;
	logic [DIVD_W-1:0] div_den;

	assign p_a    = p_q[cmd.axis];
	assign v_a    = v_q[cmd.axis];
	assign d_a    = d_q[cmd.axis];
	assign prev_a = prev_q[cmd.axis];

	always_comb begin
		unique case (cmd.op)
			OP_GMUL: begin mul_a = {16'b0, dt_q};  mul_b = {12'b0, GRAV_MAG}; end
			OP_MMUL: begin mul_a = mag32(v_a);     mul_b = {16'b0, dt_q}; end
			OP_SMUL: begin mul_a = mag32(d_a);     mul_b = mag32(d_a); end
			OP_PMUL: begin mul_a = mag32(d_a);     mul_b = {11'b0, md_q}; end
			OP_DMUL: begin mul_a = mag32(v_a);     mul_b = {16'b0, DAMP_Q16}; end
			default: begin mul_a = '0;             mul_b = '0; end
		endcase
	end

	assign rnd_sum  = mul_q + 64'd32768;
	assign rnd16    = rnd_sum[63:16];
	assign md_sq    = {21'b0, md_q} * {21'b0, md_q};
	assign sq_t     = sq_r_q + sq_bit_q;
	assign dt_div   = (dt_q == '0) ? 16'd1 : dt_q;
	assign den_v    = {4'b0, dt_div} * DRAG_DIV;
	assign np       = sat32(64'(prev_a) + sgn_apply(neg_q, div_q));
	assign drag_w   = 64'(np) - 64'(p_a);
	assign drag_mag = drag_q[32] ? 33'(-drag_q) : 33'(drag_q);

	assign div_start = (cmd.op == OP_PDIV) || (cmd.op == OP_VDIV);
	assign div_num   = (cmd.op == OP_PDIV) ? mul_q[DIVN_W-1:0] : {5'b0, drag_mag, 16'b0};
	assign div_den   = (cmd.op == OP_PDIV) ? {1'b0, sq_r_q[31:0]} : {13'b0, den_v};

	rcp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quo   (div_q)
	);

	// state memories
	always_ff @(posedge clk) begin
		rd_pos_q <= mem_pos[idx];
		rd_vel_q <= mem_vel[idx];
		if (cmd.op == OP_CLEAR) begin
			mem_pos[idx] <= {32'd0, 32'(idx) * {20'b0, RESET_SPACING}, 32'd0};
			mem_vel[idx] <= '0;
		end else if (cmd.op == OP_WRITE) begin
			mem_pos[idx] <= {p_q[2], p_q[1], p_q[0]};
			mem_vel[idx] <= {v_q[2], v_q[1], v_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_q        <= MD_W'(RESET_SPACING);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				md_q <= cfg_wdata;
			end
			if (cmd.op == OP_EMIT || cmd.op == OP_EMIT0) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_TAKE: begin
				prev_q[0] <= anchor_x;
				prev_q[1] <= anchor_y;
				prev_q[2] <= anchor_z;
				dt_q      <= step_time;
			end
			OP_GSET: gain_q <= sat32(sgn_apply(1'b1, {6'b0, rnd16}));
			OP_EMIT0: begin
				point_index <= '0;
				pos_x       <= prev_q[0];
				pos_y       <= prev_q[1];
				pos_z       <= prev_q[2];
				last_point  <= 1'b0;
			end
			OP_LOAD: begin
				p_q[0] <= rd_pos_q[31:0];
				p_q[1] <= rd_pos_q[63:32];
				p_q[2] <= rd_pos_q[95:64];
				v_q[0] <= rd_vel_q[31:0];
				v_q[1] <= rd_vel_q[63:32];
				v_q[2] <= rd_vel_q[95:64];
				sum_q  <= '0;
			end
			OP_GRAV: v_q[1] <= sat32(64'(v_q[1]) + 64'(gain_q));
			OP_GMUL, OP_SMUL: mul_q <= mul_a * mul_b;
			OP_MMUL, OP_DMUL: begin
				mul_q <= mul_a * mul_b;
				neg_q <= v_a[31];
			end
			OP_PMUL: begin
				mul_q <= mul_a * mul_b;
				neg_q <= d_a[31];
			end
			OP_MADD: p_q[cmd.axis] <= sat32(64'(p_a) + sgn_apply(neg_q, {6'b0, rnd16}));
			OP_DIFF: d_q[cmd.axis] <= sat32(64'(p_a) - 64'(prev_a));
			OP_SACC: sum_q <= sum_q + mul_q;
			OP_CMP: begin
				sq_n_q   <= sum_q;
				sq_r_q   <= '0;
				sq_bit_q <= 64'h4000_0000_0000_0000;
			end
			OP_SQRT: begin
				if (sq_n_q >= sq_t) begin
					sq_n_q <= sq_n_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			OP_PADD: begin
				p_q[cmd.axis] <= np;
				drag_q        <= drag_w[32:0];
			end
			OP_VDIV: neg_q <= drag_q[32];
			OP_VSET: v_q[cmd.axis] <= sat32(sgn_apply(neg_q, div_q));
			OP_DSET: v_q[cmd.axis] <= sat32(sgn_apply(neg_q, {6'b0, rnd16}));
			OP_WRITE: begin
				prev_q[0] <= p_q[0];
				prev_q[1] <= p_q[1];
				prev_q[2] <= p_q[2];
			end
			OP_EMIT: begin
				point_index <= IDX_W'(idx);
				pos_x       <= p_q[0];
				pos_y       <= p_q[1];
				pos_z       <= p_q[2];
				last_point  <= (idx == IW'(NUM_POINTS - 1));
			end
			default: begin
			end
		endcase
	end

	assign sts.far      = sum_q > {22'b0, md_sq};
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;

endmodule

[rtl/rcp_ctrl.sv]
module rcp_ctrl #(
	parameter int NUM_POINTS = 32,
	parameter int IW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rcp_pkg::sts_t sts,
	output rcp_pkg::cmd_t cmd,
	output logic [IW-1:0] idx
);
	import rcp_pkg::*;

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_G1   = 5'd2;
	localparam logic [4:0] S_G2   = 5'd3;
	localparam logic [4:0] S_E0   = 5'd4;
	localparam logic [4:0] S_RD   = 5'd5;
	localparam logic [4:0] S_LD   = 5'd6;
	localparam logic [4:0] S_GR   = 5'd7;
	localparam logic [4:0] S_M1   = 5'd8;
	localparam logic [4:0] S_M2   = 5'd9;
	localparam logic [4:0] S_DF   = 5'd10;
	localparam logic [4:0] S_S1   = 5'd11;
	localparam logic [4:0] S_S2   = 5'd12;
	localparam logic [4:0] S_CMP  = 5'd13;
	localparam logic [4:0] S_SQ   = 5'd14;
	localparam logic [4:0] S_P1   = 5'd15;
	localparam logic [4:0] S_P2   = 5'd16;
	localparam logic [4:0] S_PW   = 5'd17;
	localparam logic [4:0] S_P3   = 5'd18;
	localparam logic [4:0] S_V1   = 5'd19;
	localparam logic [4:0] S_VW   = 5'd20;
	localparam logic [4:0] S_V2   = 5'd21;
	localparam logic [4:0] S_D1   = 5'd22;
	localparam logic [4:0] S_D2   = 5'd23;
	localparam logic [4:0] S_WR   = 5'd24;
	localparam logic [4:0] S_EM   = 5'd25;

	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_POINTS - 1);

	logic [4:0]    state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [1:0]    axis_q, axis_d;
	logic [4:0]    cnt_q, cnt_d;
	logic [4:0]    op;

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		axis_d   = axis_q;
		cnt_d    = cnt_q;
		op       = OP_NOP;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLR: begin
				op = OP_CLEAR;
				if (idx_q == LAST_IDX) begin
					idx_d   = '0;
					state_d = S_IDLE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_TAKE;
					state_d = S_G1;
				end
			end
			S_G1: begin op = OP_GMUL; state_d = S_G2; end
			S_G2: begin op = OP_GSET; state_d = S_E0; end
			S_E0: begin
				if (sts.out_free) begin
					op      = OP_EMIT0;
					idx_d   = IW'(1);
					state_d = S_RD;
				end
			end
			S_RD: state_d = S_LD;
			S_LD: begin op = OP_LOAD; axis_d = '0; state_d = S_GR; end
			S_GR: begin op = OP_GRAV; state_d = S_M1; end
			S_M1: begin op = OP_MMUL; state_d = S_M2; end
			S_M2: begin op = OP_MADD; state_d = S_DF; end
			S_DF: begin op = OP_DIFF; state_d = S_S1; end
			S_S1: begin op = OP_SMUL; state_d = S_S2; end
			S_S2: begin
				op = OP_SACC;
				if (axis_q == 2'd2) begin
					axis_d  = '0;
					state_d = S_CMP;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_M1;
				end
			end
			S_CMP: begin
				op    = OP_CMP;
				cnt_d = '0;
				state_d = sts.far ? S_SQ : S_D1;
			end
			S_SQ: begin
				op    = OP_SQRT;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					state_d = S_P1;
				end
			end
			S_P1: begin op = OP_PMUL; state_d = S_P2; end
			S_P2: begin op = OP_PDIV; state_d = S_PW; end
			S_PW: if (!sts.div_busy) state_d = S_P3;
			S_P3: begin op = OP_PADD; state_d = S_V1; end
			S_V1: begin op = OP_VDIV; state_d = S_VW; end
			S_VW: if (!sts.div_busy) state_d = S_V2;
			S_V2: begin
				op = OP_VSET;
				if (axis_q == 2'd2) begin
					state_d = S_WR;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_P1;
				end
			end
			S_D1: begin op = OP_DMUL; state_d = S_D2; end
			S_D2: begin
				op = OP_DSET;
				if (axis_q == 2'd2) begin
					state_d = S_WR;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_D1;
				end
			end
			S_WR: begin op = OP_WRITE; state_d = S_EM; end
			S_EM: begin
				if (sts.out_free) begin
					op = OP_EMIT;
					if (idx_q == LAST_IDX) begin
						idx_d   = '0;
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + IW'(1);
						state_d = S_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q   <= '0;
			axis_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			axis_q  <= axis_d;
			cnt_q   <= cnt_d;
		end
	end

	assign cmd.op   = op;
	assign cmd.axis = axis_q;
	assign idx      = idx_q;

endmodule

[rtl/rope_chain_physics_step.sv]
// channel   direction  handshake            payload
// cfg       in         cfg_we               cfg_wdata (max_dist, unsigned Q5.16)
// in        in         in_valid/in_ready    anchor_x/y/z, step_time
// out       out        out_valid/out_ready  point_index, pos_x/y/z, last_point
//
// one request in gives NUM_POINTS results; a point that is pulled back to the spacing
// limit also takes a square root and six divides on the shared divider
// after reset a clearing pass over all NUM_POINTS points loads the rest line before in_ready
// a stalled output holds the walk at that point; the output register frees the datapath
module rope_chain_physics_step #(
	parameter int NUM_POINTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [20:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] anchor_x,
	input  logic [31:0] anchor_y,
	input  logic [31:0] anchor_z,
	input  logic [15:0] step_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  point_index,
	output logic [31:0] pos_x,
	output logic [31:0] pos_y,
	output logic [31:0] pos_z,
	output logic        last_point
);
	import rcp_pkg::*;

	// point address width into the state memories
	localparam int IW = $clog2(NUM_POINTS);

	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] idx;

	// sequencer: clear pass, then per request walks points and axes
	rcp_ctrl #(
		.NUM_POINTS(NUM_POINTS),
		.IW        (IW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd),
		.idx     (idx)
	);

	// memories, shared multiplier, square root, divider and output register
	rcp_dp #(
		.NUM_POINTS(NUM_POINTS),
		.IW        (IW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.idx        (idx),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.anchor_x   (anchor_x),
		.anchor_y   (anchor_y),
		.anchor_z   (anchor_z),
		.step_time  (step_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_index(point_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.last_point (last_point)
	);

endmodule

[tb/sv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rcp_pkg::*;

	localparam int NPTS = 32;

	// one emitted point of the chain
	typedef struct {
		logic [5:0]  idx;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        last;
	} chain_point_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [20:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] anchor_x = '0;
	logic [31:0] anchor_y = '0;
	logic [31:0] anchor_z = '0;
	logic [15:0] step_time = 16'd1;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  point_index;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic        last_point;

	rope_chain_physics_step #(.NUM_POINTS(NPTS)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.anchor_x   (anchor_x),
		.anchor_y   (anchor_y),
		.anchor_z   (anchor_z),
		.step_time  (step_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_index(point_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.last_point (last_point)
	);

	always #5 clk = ~clk;

	// chain state mirrored by the predictor
	longint         chain_pos[NPTS][3];
	longint         chain_vel[NPTS][3];
	longint         spacing_limit;
	chain_point_t   pending_points[$];
	int             mismatch_count = 0;
	bit             calm = 1'b0;      // no idling on either side when set
	int             hold_cycles = 0;  // receiver hold-off, counted down per cycle

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// nearest, ties away from zero
	function automatic longint round_div(input longint num, input longint den);
		bit neg;
		longint unsigned m;
		longint unsigned q;
		neg = num < 0;
		m = neg ? longint'(-num) : longint'(num);
		q = (m + longint'(den) / 2) / longint'(den);
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic void rest_chain();
		for (int i = 0; i < NPTS; i++) begin
			for (int a = 0; a < 3; a++) begin
				chain_pos[i][a] = 0;
				chain_vel[i][a] = 0;
			end
			chain_pos[i][1] = i * longint'(RESET_SPACING);
		end
		spacing_limit = longint'(RESET_SPACING);
	endfunction

	// walk the chain for one step and queue every emitted point
	function automatic void advance_chain(input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] az, input logic [15:0] st);
		longint dt;
		longint dt_div;
		longint prev[3];
		longint d[3];
		longint unsigned sum;
		longint unsigned mag;
		longint len;
		longint np;
		chain_point_t cp;
		dt = longint'({48'd0, st});
		dt_div = (dt == 0) ? 1 : dt;
		chain_pos[0][0] = longint'($signed(ax));
		chain_pos[0][1] = longint'($signed(ay));
		chain_pos[0][2] = longint'($signed(az));
		for (int a = 0; a < 3; a++) prev[a] = chain_pos[0][a];
		for (int i = 1; i < NPTS; i++) begin
			sum = 0;
			chain_vel[i][1] = clamp32(chain_vel[i][1]
				+ round_div(-longint'(GRAV_MAG) * dt, 65536));
			for (int a = 0; a < 3; a++) begin
				chain_pos[i][a] = clamp32(chain_pos[i][a] + round_div(chain_vel[i][a] * dt, 65536));
				d[a] = clamp32(chain_pos[i][a] - prev[a]);
				mag = (d[a] < 0) ? longint'(-d[a]) : longint'(d[a]);
				sum += mag * mag;
			end
			if (sum > longint'(spacing_limit) * longint'(spacing_limit)) begin
				// stretched too far: pull back onto the limit and take a drag velocity
				len = longint'(floor_sqrt(sum));
				for (int a = 0; a < 3; a++) begin
					np = clamp32(prev[a] + round_div(d[a] * spacing_limit, len));
					chain_vel[i][a] = clamp32(round_div((np - chain_pos[i][a]) * 65536,
						longint'(DRAG_DIV) * dt_div));
					chain_pos[i][a] = np;
				end
			end else begin
				for (int a = 0; a < 3; a++)
					chain_vel[i][a] = clamp32(round_div(chain_vel[i][a] * longint'(DAMP_Q16),
						65536));
			end
			for (int a = 0; a < 3; a++) prev[a] = chain_pos[i][a];
		end
		for (int i = 0; i < NPTS; i++) begin
			cp.idx  = i[5:0];
			cp.x    = chain_pos[i][0][31:0];
			cp.y    = chain_pos[i][1][31:0];
			cp.z    = chain_pos[i][2][31:0];
			cp.last = (i == NPTS - 1);
			pending_points.insert(pending_points.size(), cp);
		end
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// result checker, sampled at the edge where the result is taken
	always @(posedge clk) begin
		chain_point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				report("unexpected result", {26'd0, point_index}, 32'd0);
			end else begin
				want = pending_points.pop_front();
				if (point_index !== want.idx)
					report("point_index", {26'd0, point_index}, {26'd0, want.idx});
				if (pos_x !== want.x) report("pos_x", pos_x, want.x);
				if (pos_y !== want.y) report("pos_y", pos_y, want.y);
				if (pos_z !== want.z) report("pos_z", pos_z, want.z);
				if (last_point !== want.last)
					report("last_point", {31'd0, last_point}, {31'd0, want.last});
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when asked
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 37);
		end
	end

	// send one step request; in_valid stays high into the next call
	task automatic send_step(input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] az, input logic [15:0] st);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		anchor_x  <= ax;
		anchor_y  <= ay;
		anchor_z  <= az;
		step_time <= st;
		do @(posedge clk); while (!in_ready);
		advance_chain(ax, ay, az, st);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_spacing(input logic [20:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		spacing_limit = longint'({43'd0, v});
	endtask

	function automatic logic [31:0] near_coord();
		if ($urandom_range(9) == 0) return $urandom;
		return $signed($urandom_range(1 << 19)) - 32'sd262144;
	endfunction

	function automatic logic [15:0] rand_step();
		case ($urandom_range(3))
			0: return 16'($urandom_range(65535, 1));
			1: return 16'($urandom_range(64, 1));
			default: return 16'($urandom_range(2000, 100));
		endcase
	endfunction

	task automatic test_directed();
		// zero distance: point 1 sits on the anchor and does not move
		send_step(32'd0, 32'd3277, 32'd0, 16'd1);
		send_step(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'd1);
		// huge delta that saturates each component
		send_step(32'h80000000, 32'h80000000, 32'h80000000, 16'hffff);
		send_step(32'h7fffffff, 32'h80000000, 32'h00000000, 16'hffff);
		send_step(32'h0, 32'h0, 32'h0, 16'hffff);
		send_step(32'hffffffff, 32'h00000001, 32'hfffffffe, 16'd655);
		send_step(32'h00010000, 32'hffff0000, 32'h00008000, 16'd1092);
		send_step(32'h0, 32'h0, 32'h0, 16'd1);
		wait_drained();
	endtask

	task automatic test_spacing_sweep();
		logic [20:0] settings[4] = '{21'd1, 21'd1048576, 21'd65536, 21'd3277};
		foreach (settings[k]) begin
			write_spacing(settings[k]);
			repeat (6) send_step(near_coord(), near_coord(), near_coord(), rand_step());
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		// hold the receiver off while the sender keeps offering steps
		hold_cycles = 3000;
		repeat (4) send_step(near_coord(), near_coord(), near_coord(), rand_step());
		wait_drained();
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++) begin
			calm = (n >= 60 && n < 90);
			if (n % 50 == 25)
				write_spacing(21'($urandom_range(1048576, 1)));
			send_step(near_coord(), near_coord(), near_coord(), rand_step());
		end
		calm = 1'b0;
		wait_drained();
	endtask

	initial begin
		rest_chain();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_spacing_sweep();
		test_backpressure();
		test_random(254);
		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && pending_points.size() == 0) begin
			$display("rope_chain_physics_step verification clean");
		end else begin
			$display("rope_chain_physics_step verification failed");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("rope_chain_physics_step verification failed");
		$finish;
	end

endmodule
